### hw/rtl/time_window_smallest_three_unit_assert.svh
// assertion macros for the time window smallest three unit
// TWSS_ASSERT_SAME: consequent checked in the same cycle as the antecedent
// TWSS_ASSERT_NEXT: consequent checked in the cycle after the antecedent
`ifndef TIME_WINDOW_SMALLEST_THREE_UNIT_ASSERT_SVH
`define TIME_WINDOW_SMALLEST_THREE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TWSS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);
`define TWSS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TWSS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg)
`define TWSS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

### hw/rtl/twss_pkg.sv
`timescale 1ns / 1ps
package twss_pkg;

  // ring depth default
  localparam int DEPTH_DEF = 256;

  // operation codes
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_DROP   = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // field widths
  localparam int TIME_W  = 48;
  localparam int SIZE_W  = 16;
  localparam int AVG_W   = 24;
  localparam int HELD_W  = 8;
  localparam int SUM_W   = SIZE_W + 2;
  localparam int FRAC_W  = 8;

  // divide by three as multiply by reciprocal, exact for operands below 2^32
  localparam int          RECIP3_W     = 32;
  localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
  localparam int          RECIP3_SHIFT = 33;
  localparam int          PROD_W       = SUM_W + FRAC_W + RECIP3_W;

  // largest size, start value of the running minima
  localparam logic [SIZE_W-1:0] SIZE_MAX = 16'hFFFF;

  // input beat
  typedef struct packed {
    logic [1:0]        func;
    logic [TIME_W-1:0] timestamp;
    logic [SIZE_W-1:0] packet_size;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [AVG_W-1:0]  average_q8;
    logic              enough_packets;
    logic [HELD_W-1:0] held_count;
    logic              overflow;
  } out_item_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_DROP_RD,
    ST_DROP_CMP,
    ST_Q_INIT,
    ST_Q_RUN,
    ST_Q_DRAIN,
    ST_Q_SUM,
    ST_Q_MUL,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic append;
    logic drop_rd;
    logic drop_step;
    logic q_init;
    logic q_issue;
    logic sum_en;
    logic mul_en;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop_go;
    logic enough;
    logic last_issue;
  } stat_t;

endpackage

### hw/rtl/twss_ctrl.sv
`timescale 1ns / 1ps
module twss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_func,
  input  twss_pkg::stat_t   stat,
  output twss_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              out_valid
);

  twss_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      twss_pkg::ST_IDLE: begin
        if (start) begin
          case (in_func)
            twss_pkg::FUNC_APPEND: state_nxt = twss_pkg::ST_APPEND;
            twss_pkg::FUNC_DROP:   state_nxt = twss_pkg::ST_DROP_RD;
            twss_pkg::FUNC_QUERY:  state_nxt = twss_pkg::ST_Q_INIT;
            default:               state_nxt = twss_pkg::ST_DONE;
          endcase
        end
      end
      twss_pkg::ST_APPEND:   state_nxt = twss_pkg::ST_DONE;
      twss_pkg::ST_DROP_RD:  state_nxt = twss_pkg::ST_DROP_CMP;
      twss_pkg::ST_DROP_CMP: begin
        if (!stat.drop_go) begin
          state_nxt = twss_pkg::ST_DONE;
        end
      end
      twss_pkg::ST_Q_INIT: begin
        state_nxt = stat.enough ? twss_pkg::ST_Q_RUN : twss_pkg::ST_DONE;
      end
      twss_pkg::ST_Q_RUN: begin
        if (stat.last_issue) begin
          state_nxt = twss_pkg::ST_Q_DRAIN;
        end
      end
      twss_pkg::ST_Q_DRAIN:  state_nxt = twss_pkg::ST_Q_SUM;
      twss_pkg::ST_Q_SUM:    state_nxt = twss_pkg::ST_Q_MUL;
      twss_pkg::ST_Q_MUL:    state_nxt = twss_pkg::ST_DONE;
      twss_pkg::ST_DONE:     state_nxt = twss_pkg::ST_IDLE;
      default:               state_nxt = twss_pkg::ST_IDLE;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      twss_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      twss_pkg::ST_APPEND:   cmd.append    = 1'b1;
      twss_pkg::ST_DROP_RD:  cmd.drop_rd   = 1'b1;
      twss_pkg::ST_DROP_CMP: cmd.drop_step = stat.drop_go;
      twss_pkg::ST_Q_INIT:   cmd.q_init    = stat.enough;
      twss_pkg::ST_Q_RUN:    cmd.q_issue   = 1'b1;
      twss_pkg::ST_Q_DRAIN:  cmd           = '0;
      twss_pkg::ST_Q_SUM:    cmd.sum_en    = 1'b1;
      twss_pkg::ST_Q_MUL:    cmd.mul_en    = 1'b1;
      twss_pkg::ST_DONE:     out_valid     = 1'b1;
      default:               cmd           = '0;
    endcase
  end

endmodule

### hw/rtl/twss_dp.sv
`timescale 1ns / 1ps
module twss_dp #(
  parameter int DEPTH = twss_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  twss_pkg::in_item_t   in_item,
  input  twss_pkg::cmd_t       cmd,
  output twss_pkg::stat_t      stat,
  output twss_pkg::out_item_t  out_item
);

  localparam int AW = $clog2(DEPTH);

  // entry stores
  logic [twss_pkg::TIME_W-1:0] time_mem [DEPTH];
  logic [twss_pkg::SIZE_W-1:0] size_mem [DEPTH];

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] rd_addr;
  logic          rd_vld_r;
  logic [twss_pkg::TIME_W-1:0] rd_time_r;
  logic [twss_pkg::SIZE_W-1:0] rd_size_r;

  twss_pkg::in_item_t op_r;

  logic [twss_pkg::SIZE_W-1:0] s1_r, s2_r, s3_r, s1_nxt, s2_nxt, s3_nxt;
  logic [twss_pkg::SUM_W-1:0]  sum_r;
  logic [twss_pkg::PROD_W-1:0] prod_r;
  logic                        enough_r;
  logic                        ovf_r;

  logic [AW:0]   diff;
  logic [AW-1:0] live;
  logic [AW+twss_pkg::HELD_W-1:0] live_ext;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc;
  logic          full;

  // ring index step
  function automatic logic [AW-1:0] nxt_slot(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    r = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    return r;
  endfunction

  // occupancy
  assign diff     = {1'b0, tail_r} - {1'b0, head_r};
  assign live     = diff[AW] ? AW'(diff + (AW+1)'(DEPTH)) : diff[AW-1:0];
  assign live_ext = {{twss_pkg::HELD_W{1'b0}}, live};
  assign head_inc = nxt_slot(head_r);
  assign tail_inc = nxt_slot(tail_r);
  assign full     = (tail_inc == head_r);

  // status to controller
  assign stat.drop_go    = (head_r != tail_r) && (rd_time_r < op_r.timestamp);
  assign stat.enough     = (live >= AW'(3));
  assign stat.last_issue = (cnt_r == AW'(1));

  // read address: speculative one ahead while dropping
  always_comb begin
    if (cmd.q_issue) begin
      rd_addr = rd_ptr_r;
    end else if (cmd.drop_step) begin
      rd_addr = nxt_slot(head_inc);
    end else begin
      rd_addr = head_inc;
    end
  end

  // index updates
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (cmd.append && !full) begin
      tail_nxt = tail_inc;
    end
    if (cmd.drop_step) begin
      head_nxt = head_inc;
    end
    if (cmd.q_init) begin
      rd_ptr_nxt = head_inc;
      cnt_nxt    = live;
    end else if (cmd.q_issue) begin
      rd_ptr_nxt = nxt_slot(rd_ptr_r);
      cnt_nxt    = cnt_r - AW'(1);
    end
  end

  // three smallest, insertion on each returned beat
  always_comb begin
    s1_nxt = s1_r;
    s2_nxt = s2_r;
    s3_nxt = s3_r;
    if (cmd.q_init) begin
      s1_nxt = twss_pkg::SIZE_MAX;
      s2_nxt = twss_pkg::SIZE_MAX;
      s3_nxt = twss_pkg::SIZE_MAX;
    end else if (rd_vld_r) begin
      if (rd_size_r < s1_r) begin
        s3_nxt = s2_r;
        s2_nxt = s1_r;
        s1_nxt = rd_size_r;
      end else if (rd_size_r < s2_r) begin
        s3_nxt = s2_r;
        s2_nxt = rd_size_r;
      end else if (rd_size_r < s3_r) begin
        s3_nxt = rd_size_r;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      rd_vld_r <= cmd.q_issue;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    cnt_r    <= cnt_nxt;
    s1_r     <= s1_nxt;
    s2_r     <= s2_nxt;
    s3_r     <= s3_nxt;
    if (cmd.load) begin
      op_r     <= in_item;
      enough_r <= 1'b0;
      ovf_r    <= 1'b0;
    end
    if (cmd.append) begin
      ovf_r <= full;
    end
    if (cmd.q_init) begin
      enough_r <= 1'b1;
    end
    if (cmd.sum_en) begin
      sum_r <= twss_pkg::SUM_W'(s1_r) + twss_pkg::SUM_W'(s2_r) + twss_pkg::SUM_W'(s3_r);
    end
    if (cmd.mul_en) begin
      prod_r <= twss_pkg::PROD_W'({sum_r, {twss_pkg::FRAC_W{1'b0}}})
              * twss_pkg::PROD_W'(twss_pkg::RECIP3);
    end
  end

  // entry store write port
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      time_mem[tail_inc] <= op_r.timestamp;
      size_mem[tail_inc] <= op_r.packet_size;
    end
  end

  // entry store read port
  always_ff @(posedge clk) begin
    rd_time_r <= time_mem[rd_addr];
    rd_size_r <= size_mem[rd_addr];
  end

  // result beat
  assign out_item.average_q8     = enough_r ? prod_r[twss_pkg::RECIP3_SHIFT +: twss_pkg::AVG_W]
                                            : '0;
  assign out_item.enough_packets = enough_r;
  assign out_item.held_count     = live_ext[twss_pkg::HELD_W-1:0];
  assign out_item.overflow       = ovf_r;

endmodule

### hw/rtl/time_window_smallest_three_unit.sv
`timescale 1ns / 1ps
// channel   ports                       direction  notes
// input     start, busy, in_item        in / out   beat taken when start && !busy
// result    out_valid, out_item         out        one-cycle strobe, one per beat
//
// result strobe follows an accepted beat: append writes the entry, an unknown code goes
// straight to the strobe, drop reads then drops the oldest entry while older than the beat's timestamp,
// query scans the n entries held (skipped if n < 3), one stored entry a cycle through the single
// read port of the entry stores, then drains, sums and multiplies
// synchronous active-low reset clears the ring to empty; stores are not cleared
// busy stays high until the result strobe; the result side cannot stall
`include "time_window_smallest_three_unit_assert.svh"
module time_window_smallest_three_unit #(
  parameter int DEPTH = twss_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  twss_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output twss_pkg::out_item_t  out_item
);

  twss_pkg::cmd_t  cmd;
  twss_pkg::stat_t stat;

  // sequencing
  twss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_item.func),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // ring, scan and average
  twss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  // checks
  `TWSS_ASSERT_SAME(a_strobe_busy, clk, rst_n, out_valid, busy, "result strobe while idle")
  `TWSS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted beat not held busy")
  `TWSS_ASSERT_NEXT(a_strobe_idle, clk, rst_n, out_valid, !busy && !out_valid, "no return to idle")
  `TWSS_ASSERT_SAME(a_avg_zero, clk, rst_n, out_valid && !out_item.enough_packets,
                    out_item.average_q8 == '0, "average without enough entries")

endmodule
